FILE: rtl/core/disk_dilation_outline_ring_core_macros.svh
// assertion macros shared by the outline ring core
// uses the clk and rst_n names of the module that expands them
`ifndef DISK_DILATION_OUTLINE_RING_CORE_MACROS_SVH
`define DISK_DILATION_OUTLINE_RING_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define DDOR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define DDOR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DDOR_ASSERT_IMP(lbl, ante, cons, msg)
`define DDOR_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/core/ddor_pkg.sv
// types, sizes and helpers of the outline ring core
// no dependencies
package ddor_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 8;

  // fixed field widths
  localparam int PIX_W      = 8;
  localparam int POS_W      = 10;
  localparam int CFG_DIM_W  = 11;
  localparam int CFG_RAD_W  = 4;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  // derived sizes
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int YW     = $clog2(MAX_HEIGHT + MAX_RADIUS + 2);
  localparam int QYW    = $clog2(MAX_HEIGHT);
  localparam int RADW   = $clog2(MAX_RADIUS + 1);
  localparam int NSLOT  = 2 * MAX_RADIUS + 1;
  localparam int NROW   = 2 * MAX_RADIUS + 1;
  localparam int NH     = MAX_RADIUS + 1;
  localparam int HIW    = $clog2(NH);
  localparam int SLW    = $clog2(NSLOT);
  localparam int NG     = (NSLOT + 3) / 4;
  localparam int DLYW   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int MEM_W  = 2 * MAX_RADIUS * PIX_W;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STROKE_RADIUS = 2'd2;

  // register reset values
  localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH   = 11'd1024;
  localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT  = 11'd1024;
  localparam logic [CFG_RAD_W-1:0] RST_STROKE_RADIUS = 4'd1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [NH-1:0][PIX_W-1:0] colmax_t;

  typedef struct packed {
    logic [WW-1:0]   width;
    logic [HW-1:0]   height;
    logic [RADW-1:0] radius;
  } geom_t;

  typedef struct packed {
    logic            emit;
    logic [XW-1:0]   qx;
    logic [QYW-1:0]  qy;
    logic            last;
  } meta_t;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    pix_t          pix;
    meta_t         meta;
  } item_t;

  // largest vertical half extent of the disk at horizontal offset d
  function automatic logic [HIW-1:0] disk_half(input logic [RADW-1:0] r,
                                                input logic [SLW-1:0] d);
    int rr;
    int dd;
    int res;
    int h;
    rr  = int'(r) * int'(r);
    dd  = int'(d) * int'(d);
    res = 0;
    for (h = 0; h <= MAX_RADIUS; h++) begin
      if (h * h + dd <= rr) res = h;
    end
    return HIW'(res);
  endfunction

endpackage

FILE: rtl/core/ddor_if.sv
// request channels of the outline ring core: coverage in, ring pixel out
// depends on ddor_pkg
interface ddor_in_if import ddor_pkg::*; ();
  logic valid;
  logic ready;
  pix_t coverage;
  logic drain;
  modport source (output valid, coverage, drain, input ready);
  modport sink (input valid, coverage, drain, output ready);
endinterface

interface ddor_out_if import ddor_pkg::*; ();
  logic             valid;
  logic             ready;
  pix_t             alpha;
  pix_t             color;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic             frame_end;
  modport source (output valid, alpha, color, pos_x, pos_y, frame_end, input ready);
  modport sink (input valid, alpha, color, pos_x, pos_y, frame_end, output ready);
endinterface

FILE: rtl/core/ddor_ram.sv
// generic single-port-write, single-port-read ram with registered read
// read returns the old word when the same address is written in that cycle
module ddor_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/ddor_ctrl.sv
// configuration registers, frame geometry and raster position counters
// depends on ddor_pkg and the assertion macros
`include "disk_dilation_outline_ring_core_macros.svh"
module ddor_ctrl import ddor_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  take,
  input  pix_t                  coverage,
  input  logic                  drain,
  output geom_t                 geom,
  output item_t                 item
);

  logic [CFG_DIM_W-1:0] fw_r, fw_nxt, fh_r, fh_nxt;
  logic [CFG_RAD_W-1:0] rad_r, rad_nxt;
  logic [XW-1:0]        xi_r, xi_nxt, qx_r, qx_nxt;
  logic [YW-1:0]        yi_r, yi_nxt;
  logic [QYW-1:0]       qy_r, qy_nxt;
  logic [DLYW-1:0]      n_r, n_nxt;
  logic [DLYW-1:0]      delay;
  logic                 emit, in_frame, x_end, qx_end, qy_end, last, restart;

  // clamped geometry
  always_comb begin
    if (fw_r == '0) geom.width = WW'(1);
    else if (int'(fw_r) > MAX_WIDTH) geom.width = WW'(MAX_WIDTH);
    else geom.width = WW'(fw_r);
    if (fh_r == '0) geom.height = HW'(1);
    else if (int'(fh_r) > MAX_HEIGHT) geom.height = HW'(MAX_HEIGHT);
    else geom.height = HW'(fh_r);
    if (rad_r == '0) geom.radius = RADW'(1);
    else if (int'(rad_r) > MAX_RADIUS) geom.radius = RADW'(MAX_RADIUS);
    else geom.radius = RADW'(rad_r);
  end

  // lag between a pixel and its result, in items
  assign delay = DLYW'(geom.radius) * DLYW'(geom.width) + DLYW'(geom.radius);

  // current item
  assign emit     = n_r >= delay;
  assign in_frame = int'(yi_r) < int'(geom.height);
  assign x_end    = int'(xi_r) == int'(geom.width) - 1;
  assign qx_end   = int'(qx_r) == int'(geom.width) - 1;
  assign qy_end   = int'(qy_r) == int'(geom.height) - 1;
  assign last     = emit && qx_end && qy_end;

  assign item.x         = xi_r;
  assign item.y         = yi_r;
  assign item.pix       = (drain || !in_frame) ? '0 : coverage;
  assign item.meta.emit = emit;
  assign item.meta.qx   = qx_r;
  assign item.meta.qy   = qy_r;
  assign item.meta.last = last;

  // next state
  always_comb begin
    fw_nxt  = fw_r;
    fh_nxt  = fh_r;
    rad_nxt = rad_r;
    xi_nxt  = xi_r;
    yi_nxt  = yi_r;
    qx_nxt  = qx_r;
    qy_nxt  = qy_r;
    n_nxt   = n_r;
    restart = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          fw_nxt  = CFG_DIM_W'(cfg_data);
          restart = 1'b1;
        end
        REG_FRAME_HEIGHT: begin
          fh_nxt  = CFG_DIM_W'(cfg_data);
          restart = 1'b1;
        end
        REG_STROKE_RADIUS: begin
          rad_nxt = cfg_data[CFG_RAD_W-1:0];
          restart = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end else if (take) begin
      if (x_end) begin
        xi_nxt = '0;
        yi_nxt = yi_r + YW'(1);
      end else begin
        xi_nxt = xi_r + XW'(1);
      end
      if (!emit) n_nxt = n_r + DLYW'(1);
      if (emit) begin
        if (qx_end) begin
          qx_nxt = '0;
          qy_nxt = qy_r + QYW'(1);
        end else begin
          qx_nxt = qx_r + XW'(1);
        end
      end
      if (last) restart = 1'b1;
    end
    if (restart) begin
      xi_nxt = '0;
      yi_nxt = '0;
      qx_nxt = '0;
      qy_nxt = '0;
      n_nxt  = '0;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= RST_FRAME_WIDTH;
      fh_r  <= RST_FRAME_HEIGHT;
      rad_r <= RST_STROKE_RADIUS;
      xi_r  <= '0;
      yi_r  <= '0;
      qx_r  <= '0;
      qy_r  <= '0;
      n_r   <= '0;
    end else begin
      fw_r  <= fw_nxt;
      fh_r  <= fh_nxt;
      rad_r <= rad_nxt;
      xi_r  <= xi_nxt;
      yi_r  <= yi_nxt;
      qx_r  <= qx_nxt;
      qy_r  <= qy_nxt;
      n_r   <= n_nxt;
    end
  end

  `DDOR_ASSERT_IMP(a_lag_bound, 1'b1, n_r <= delay, "lag counter ran past the window delay")
  `DDOR_ASSERT_NXT(a_cfg_restart, cfg_we && cfg_index == REG_STROKE_RADIUS, n_r == '0 && qx_r == '0, "radius write did not restart the frame")

endmodule

FILE: rtl/core/ddor_col.sv
// line store read-modify-write and per-column vertical disk maxima
// depends on ddor_pkg and ddor_ram
module ddor_col import ddor_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  logic    take,
  input  item_t   item,
  input  geom_t   geom,
  output logic    col_v,
  output colmax_t col_max,
  output meta_t   col_meta
);

  logic             s1_v_r, s2_v_r, s3_v_r;
  item_t            s1_item_r;
  meta_t            s2_meta_r, s3_meta_r;
  pix_t             s2_col_r [NROW];
  pix_t             s3_p_r [NH];
  logic [MEM_W-1:0] rd_data, wr_data, word;
  logic             wr_en;
  logic             fwd_r;
  logic [MEM_W-1:0] fwd_data_r;
  pix_t             cv [NROW];
  pix_t             mcol [NROW];
  pix_t             plo [NH];
  pix_t             phi [NH];
  pix_t             p [NH];
  pix_t             m [NH];

  // line store: one word per column holds the previous rows of that column
  assign wr_en = adv && s1_v_r;

  ddor_ram #(
    .W (MEM_W),
    .D (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_item_r.x),
    .wdata (wr_data),
    .re    (take),
    .raddr (item.x),
    .rdata (rd_data)
  );

  // forward a write that lands in the same cycle as the read of that column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (take) begin
      fwd_r <= wr_en && (s1_item_r.x == item.x);
    end
  end

  always_ff @(posedge clk) begin
    if (take) fwd_data_r <= wr_data;
  end

  assign word = fwd_r ? fwd_data_r : rd_data;

  // column vector, newest row first, and the shifted word written back
  always_comb begin
    cv[0] = s1_item_r.pix;
    for (int i = 1; i < NROW; i++) cv[i] = word[(i-1)*PIX_W +: PIX_W];
    for (int j = 0; j < NROW - 1; j++) wr_data[j*PIX_W +: PIX_W] = cv[j];
  end

  // rows outside the frame read as zero
  always_comb begin
    for (int i = 0; i < NROW; i++) begin
      if (int'(s1_item_r.y) >= i && int'(s1_item_r.y) - i < int'(geom.height)) mcol[i] = cv[i];
      else mcol[i] = '0;
    end
  end

  // symmetric row pairs around the center row
  always_comb begin
    for (int h = 0; h < NH; h++) begin
      plo[h] = '0;
      phi[h] = '0;
      for (int i = 0; i < NROW; i++) begin
        if (i + h == int'(geom.radius)) plo[h] = s2_col_r[i];
        if (i == int'(geom.radius) + h) phi[h] = s2_col_r[i];
      end
      p[h] = (plo[h] > phi[h]) ? plo[h] : phi[h];
    end
  end

  // running maximum over growing half heights
  always_comb begin
    m[0] = s3_p_r[0];
    for (int h = 1; h < NH; h++) m[h] = (s3_p_r[h] > m[h-1]) ? s3_p_r[h] : m[h-1];
    for (int h = 0; h < NH; h++) col_max[h] = m[h];
  end

  assign col_v    = s3_v_r;
  assign col_meta = s3_meta_r;

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= take;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= item;
      s2_meta_r <= s1_item_r.meta;
      s3_meta_r <= s2_meta_r;
      for (int i = 0; i < NROW; i++) s2_col_r[i] <= mcol[i];
      for (int h = 0; h < NH; h++) s3_p_r[h] <= p[h];
    end
  end

endmodule

FILE: rtl/core/ddor_win.sv
// disk window of column maxima, horizontal maximum tree and result register
// depends on ddor_pkg and the assertion macros
`include "disk_dilation_outline_ring_core_macros.svh"
module ddor_win import ddor_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             col_v,
  input  colmax_t          col_max,
  input  meta_t            col_meta,
  input  geom_t            geom,
  input  logic             out_ready,
  output logic             adv,
  output logic             out_valid,
  output pix_t             out_alpha,
  output pix_t             out_color,
  output logic [POS_W-1:0] out_x,
  output logic [POS_W-1:0] out_y,
  output logic             out_last
);

  colmax_t        win_r [NSLOT];
  logic [HIW-1:0] hsel_r [NSLOT];
  logic           on_r [NSLOT];
  logic           s4_v_r, s5_v_r, out_v_r, out_v_nxt;
  meta_t          s4_meta_r, s5_meta_r;
  pix_t           s5_grp_r [NG];
  pix_t           s5_self_r;
  pix_t           tap [NSLOT];
  pix_t           grp [NG];
  pix_t           self_pix, best, alpha;
  pix_t           out_alpha_r;
  logic [POS_W-1:0] out_x_r, out_y_r;
  logic           out_last_r;
  logic           load;

  // disk shape per slot, follows the radius register
  always_ff @(posedge clk) begin
    for (int k = 0; k < NSLOT; k++) begin
      hsel_r[k] <= disk_half(geom.radius, SLW'((k > int'(geom.radius)) ?
                   k - int'(geom.radius) : int'(geom.radius) - k));
      on_r[k]   <= k <= 2 * int'(geom.radius);
    end
  end

  // horizontal taps: slots off the disk or off the frame read as zero
  always_comb begin
    self_pix = '0;
    for (int k = 0; k < NSLOT; k++) begin
      if (on_r[k] && int'(s4_meta_r.qx) + int'(geom.radius) - k >= 0 &&
          int'(s4_meta_r.qx) + int'(geom.radius) - k < int'(geom.width)) begin
        tap[k] = win_r[k][hsel_r[k]];
      end else begin
        tap[k] = '0;
      end
      if (k == int'(geom.radius)) self_pix = win_r[k][0];
    end
    for (int g = 0; g < NG; g++) begin
      grp[g] = '0;
      for (int j = 0; j < 4; j++) begin
        if (g * 4 + j < NSLOT) begin
          if (tap[g*4+j] > grp[g]) grp[g] = tap[g*4+j];
        end
      end
    end
  end

  // final maximum and ring alpha
  always_comb begin
    best = '0;
    for (int g = 0; g < NG; g++) begin
      if (s5_grp_r[g] > best) best = s5_grp_r[g];
    end
    alpha = (best > s5_self_r) ? best - s5_self_r : '0;
  end

  // the pipeline holds only when a result would overwrite a waiting one
  assign adv  = !(out_v_r && !out_ready && s5_v_r && s5_meta_r.emit);
  assign load = adv && s5_v_r && s5_meta_r.emit;

  always_comb begin
    out_v_nxt = out_v_r;
    if (load) out_v_nxt = 1'b1;
    else if (out_ready) out_v_nxt = 1'b0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv) begin
        s4_v_r <= col_v;
        s5_v_r <= s4_v_r;
      end
      out_v_r <= out_v_nxt;
    end
  end

  // window shift, stage payload and result payload
  always_ff @(posedge clk) begin
    if (adv && col_v) begin
      win_r[0] <= col_max;
      for (int k = 1; k < NSLOT; k++) win_r[k] <= win_r[k-1];
    end
    if (adv) begin
      s4_meta_r <= col_meta;
      s5_meta_r <= s4_meta_r;
      s5_self_r <= self_pix;
      for (int g = 0; g < NG; g++) s5_grp_r[g] <= grp[g];
    end
    if (load) begin
      out_alpha_r <= alpha;
      out_x_r     <= POS_W'(s5_meta_r.qx);
      out_y_r     <= POS_W'(s5_meta_r.qy);
      out_last_r  <= s5_meta_r.last;
    end
  end

  assign out_valid = out_v_r;
  assign out_alpha = out_alpha_r;
  assign out_color = (out_alpha_r != '0) ? PIX_MAX : '0;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_last  = out_last_r;

  `DDOR_ASSERT_IMP(a_center_in_disk, s5_v_r && s5_meta_r.emit, best >= s5_self_r, "disk maximum below own coverage, window misaligned")
  `DDOR_ASSERT_IMP(a_end_corner, out_v_r && out_last_r, int'(out_x_r) == int'(geom.width) - 1, "frame end flagged off the last column")

endmodule

FILE: rtl/core/disk_dilation_outline_ring_core.sv
// Outline ring core: grayscale disk dilation of a coverage frame minus the pixel itself.
// Coverage bytes enter on in_ch in raster order, one request per pixel; drain requests
// after the frame (or any request past W*H pixels) count as coverage 0 and push out the
// remaining results. Each result on out_ch carries alpha, color, position and frame_end.
// The result for a pixel is released by the request R*W+R positions after it, then passes
// through the pipeline: line-store read, row masking, row pairing,
// vertical maximum into the window, horizontal group maximum, final maximum.
// One request per clock unless stalled; the line store is a single ram of 2*MAX_RADIUS
// rows per column word, read and written once per request, with same-column forwarding.
// Configuration is written on cfg_we with cfg_index/cfg_data while the core is idle; a
// write to a listed register restarts the frame. Reset restores the default geometry and
// zeroes the position counters; the line store is not cleared, since every tap read
// inside the frame was written earlier in the same frame.
// When out_ch stalls, requests are still taken until a finished result reaches the last
// stage; then in_ch.ready drops until out_ch takes the waiting result.
module disk_dilation_outline_ring_core import ddor_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ddor_in_if.sink               in_ch,
  ddor_out_if.source            out_ch
);

  geom_t   geom;
  item_t   item;
  logic    adv, take;
  logic    col_v;
  colmax_t col_max;
  meta_t   col_meta;

  // request acceptance
  assign take        = in_ch.valid && adv;
  assign in_ch.ready = adv;

  ddor_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .coverage  (in_ch.coverage),
    .drain     (in_ch.drain),
    .geom      (geom),
    .item      (item)
  );

  ddor_col u_col (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .take     (take),
    .item     (item),
    .geom     (geom),
    .col_v    (col_v),
    .col_max  (col_max),
    .col_meta (col_meta)
  );

  ddor_win u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .col_v     (col_v),
    .col_max   (col_max),
    .col_meta  (col_meta),
    .geom      (geom),
    .out_ready (out_ch.ready),
    .adv       (adv),
    .out_valid (out_ch.valid),
    .out_alpha (out_ch.alpha),
    .out_color (out_ch.color),
    .out_x     (out_ch.pos_x),
    .out_y     (out_ch.pos_y),
    .out_last  (out_ch.frame_end)
  );

endmodule
